// ===== design/vcm_pkg.sv =====
package vcm_pkg;

    // Vertex id space covered by the selection bitmap.
    localparam int unsigned MAX_VERTICES = 65536;
    localparam int unsigned MAP_AW       = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;

    localparam int unsigned VID_W   = 16;
    localparam int unsigned COUNT_W = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [VID_W-1:0]   t_vid;
    typedef logic [MAP_AW-1:0]  t_map_addr;
    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        t_vid src_vertex;
        t_vid dst_vertex;
    } t_edge_in;

    typedef struct packed {
        logic   edge_taken;
        t_count cover_size;
    } t_edge_out;

    // Status of the post-reset bitmap clearing pass.
    typedef struct packed {
        logic      busy;
        t_map_addr addr;
    } t_clr;

    function automatic logic vid_in_range(input t_vid v);
        return 32'(v) < MAX_VERTICES;
    endfunction

    function automatic t_map_addr vid_to_addr(input t_vid v);
        return MAP_AW'(v);
    endfunction

endpackage

// ===== design/vcm_map_ram.sv =====
module vcm_map_ram #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic                     i_wdata,
    input  logic                     i_ren,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic                     o_rdata0,
    output logic                     o_rdata1
);

    logic r_mem [DEPTH];
    logic r_rdata0;
    logic r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered reads, old data on a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (i_ren) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// ===== design/vcm_clear_seq.sv =====
module vcm_clear_seq
    import vcm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    output t_clr o_clr
);

    localparam t_map_addr LAST_ADDR = MAP_AW'(MAX_VERTICES - 1);

    logic      r_busy;
    t_map_addr r_addr;

    // One bitmap entry cleared per cycle after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_addr <= '0;
        end else if (r_busy) begin
            if (r_addr == LAST_ADDR) begin
                r_busy <= 1'b0;
            end else begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    assign o_clr.busy = r_busy;
    assign o_clr.addr = r_addr;

endmodule

// ===== design/vertex_cover_matching_edge_stream_core.sv =====
// Channel  | Direction | Handshake                    | Payload
// edge     | in        | i_edge_valid / o_edge_ready  | i_edge (src_vertex, dst_vertex)
// result   | out       | o_res_valid  / i_res_ready   | o_res  (edge_taken, cover_size)
//
// One edge per cycle while results drain; edges pass stage 1 and the output register.
// The rate is set by the bitmap banks: each bank takes one write and two reads per cycle.
// After reset a clearing pass zeroes all MAX_VERTICES (65536) bitmap entries with
// o_edge_ready low.
// A stalled result holds the compute stage; one more edge may still enter behind it.
module vertex_cover_matching_edge_stream_core
    import vcm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_edge_valid,
    output logic      o_edge_ready,
    input  t_edge_in  i_edge,
    output logic      o_res_valid,
    input  logic      i_res_ready,
    output t_edge_out o_res
);

    // The selected bitmap is split over two banks: bank A records the source end of
    // each matched edge, bank B the destination end. A vertex is selected when either
    // bank has its bit set, so each bank needs only one write per edge.

    t_clr clr;

    // Stage 1: edge whose bitmap reads are on the bank outputs.
    logic      r_s1_valid;
    t_vid      r_s1_src;
    t_vid      r_s1_dst;

    // Write made by the compute stage in the cycle the stage-1 edge was read.
    // The banks return pre-write data for it, so it is forwarded here.
    logic      r_fwd_valid;
    t_map_addr r_fwd_a;
    t_map_addr r_fwd_b;

    t_count    r_count;
    logic      r_out_valid;
    t_edge_out r_out;

    logic      in_fire;
    logic      s1_adv;
    logic      s1_write;
    logic      s1_range;
    logic      sel_src;
    logic      sel_dst;
    t_map_addr s1_a;
    t_map_addr s1_b;
    t_map_addr rd_a;
    t_map_addr rd_b;
    logic      a_at_src;
    logic      a_at_dst;
    logic      b_at_src;
    logic      b_at_dst;
    logic      a_we;
    logic      b_we;
    t_map_addr a_waddr;
    t_map_addr b_waddr;
    logic      wdata;
    logic [COUNT_W:0] sum;
    t_count    n_count;

    vcm_clear_seq u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_clr   (clr)
    );

    // Handshakes.
    assign s1_adv       = r_s1_valid && (!r_out_valid || i_res_ready);
    assign o_edge_ready = !clr.busy && (!r_s1_valid || s1_adv);
    assign in_fire      = i_edge_valid && o_edge_ready;

    assign rd_a = vid_to_addr(i_edge.src_vertex);
    assign rd_b = vid_to_addr(i_edge.dst_vertex);
    assign s1_a = vid_to_addr(r_s1_src);
    assign s1_b = vid_to_addr(r_s1_dst);

    // Bank writes: zeros during the clearing pass, then set bits for matched edges.
    assign a_we    = clr.busy || s1_write;
    assign b_we    = clr.busy || s1_write;
    assign a_waddr = clr.busy ? clr.addr : s1_a;
    assign b_waddr = clr.busy ? clr.addr : s1_b;
    assign wdata   = !clr.busy;

    vcm_map_ram #(.DEPTH(MAX_VERTICES)) u_bank_a (
        .i_clk    (i_clk),
        .i_we     (a_we),
        .i_waddr  (a_waddr),
        .i_wdata  (wdata),
        .i_ren    (in_fire),
        .i_raddr0 (rd_a),
        .i_raddr1 (rd_b),
        .o_rdata0 (a_at_src),
        .o_rdata1 (a_at_dst)
    );

    vcm_map_ram #(.DEPTH(MAX_VERTICES)) u_bank_b (
        .i_clk    (i_clk),
        .i_we     (b_we),
        .i_waddr  (b_waddr),
        .i_wdata  (wdata),
        .i_ren    (in_fire),
        .i_raddr0 (rd_a),
        .i_raddr1 (rd_b),
        .o_rdata0 (b_at_src),
        .o_rdata1 (b_at_dst)
    );

    // Selection test with forwarding from the previous edge's write.
    assign sel_src = a_at_src || b_at_src ||
                     (r_fwd_valid && (r_fwd_a == s1_a || r_fwd_b == s1_a));
    assign sel_dst = a_at_dst || b_at_dst ||
                     (r_fwd_valid && (r_fwd_a == s1_b || r_fwd_b == s1_b));

    assign s1_range = vid_in_range(r_s1_src) && vid_in_range(r_s1_dst);
    assign s1_write = s1_adv && s1_range && !sel_src && !sel_dst;

    // Self-loop adds one vertex, a normal edge two; saturating count.
    always_comb begin
        sum = {1'b0, r_count} + ((r_s1_src == r_s1_dst) ? (COUNT_W+1)'(1) : (COUNT_W+1)'(2));
        n_count = r_count;
        if (s1_write) begin
            n_count = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_count <= n_count;
            if (in_fire) begin
                r_s1_valid  <= 1'b1;
                r_fwd_valid <= s1_write;
            end else if (s1_adv) begin
                r_s1_valid  <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_src <= i_edge.src_vertex;
            r_s1_dst <= i_edge.dst_vertex;
            r_fwd_a  <= s1_a;
            r_fwd_b  <= s1_b;
        end
        if (s1_adv) begin
            r_out.edge_taken <= s1_write;
            r_out.cover_size <= n_count;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ===== design/vcm_checker.sv =====
module vcm_checker
    import vcm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_edge_ready,
    input logic      o_res_valid,
    input logic      i_res_ready,
    input t_edge_out o_res
);

    // Clearing pass keeps the input closed right after reset.
    a_ready_low_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_edge_ready)
        else $error("edge ready high right after reset");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("stalled result changed");

    a_taken_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.edge_taken |-> o_res.cover_size != '0)
        else $error("taken edge with empty cover");

    a_skip_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready) ##1 (o_res_valid && i_res_ready && !o_res.edge_taken)
        |-> o_res.cover_size == $past(o_res.cover_size))
        else $error("cover size moved on a skipped edge");

    a_take_grows_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready) ##1 (o_res_valid && i_res_ready && o_res.edge_taken)
        |-> (o_res.cover_size == COUNT_W'($past(o_res.cover_size) + 1'b1) ||
             o_res.cover_size == COUNT_W'($past(o_res.cover_size) + 2'd2)))
        else $error("cover size grew by a wrong amount");

endmodule

bind vertex_cover_matching_edge_stream_core vcm_checker u_vcm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_edge_ready (o_edge_ready),
    .o_res_valid  (o_res_valid),
    .i_res_ready  (i_res_ready),
    .o_res        (o_res)
);
